/* design/sttok_pkg.sv */
// Shared types, character codes, token kinds and keyword table for the
// source text tokenizer. No dependencies.
package sttok_pkg;

   localparam int POS_WIDTH       = 16;
   localparam int MAX_KEYWORD_LEN = 8;
   localparam int KW_BITS         = MAX_KEYWORD_LEN * 8;
   localparam int KW_COUNT        = 15;
   localparam int VALUE_WIDTH     = 31;
   localparam int RSPQ_DEPTH      = 4;
   localparam int RSPQ_PTR_W      = $clog2(RSPQ_DEPTH);
   localparam int RSPQ_CNT_W      = $clog2(RSPQ_DEPTH + 1);

   typedef logic [POS_WIDTH-1:0]   pos_type;
   typedef logic [VALUE_WIDTH-1:0] value_type;
   typedef logic [KW_BITS-1:0]     kw_word_type;
   typedef logic [4:0]             kind_type;

   localparam value_type INT_SAT = {VALUE_WIDTH{1'b1}};
   localparam pos_type   POS_MAX = {POS_WIDTH{1'b1}};
   localparam pos_type   POS_ONE = pos_type'(1);

   // token kinds
   localparam kind_type K_IDENT  = 5'd0;
   localparam kind_type K_INT    = 5'd1;
   localparam kind_type K_FLOAT  = 5'd2;
   localparam kind_type K_STRING = 5'd3;
   localparam kind_type K_ADD    = 5'd4;
   localparam kind_type K_SUB    = 5'd5;
   localparam kind_type K_MUL    = 5'd6;
   localparam kind_type K_DIV    = 5'd7;
   localparam kind_type K_COMMA  = 5'd8;
   localparam kind_type K_LPAREN = 5'd9;
   localparam kind_type K_RPAREN = 5'd10;
   localparam kind_type K_KW0    = 5'd11;
   localparam kind_type K_BADSTR = 5'd26;

   // character codes
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_DASH    = 8'h2D;
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;

   // keywords, last character in the low byte, zero padded above
   localparam kw_word_type KW_TEXT [KW_COUNT] = '{
      KW_BITS'("var"),   KW_BITS'("def"),   KW_BITS'("true"),     KW_BITS'("false"),
      KW_BITS'("return"), KW_BITS'("break"), KW_BITS'("continue"), KW_BITS'("if"),
      KW_BITS'("else"),  KW_BITS'("while"), KW_BITS'("do"),       KW_BITS'("and"),
      KW_BITS'("or"),    KW_BITS'("not"),   KW_BITS'("for")
   };

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      kind_type  token_kind;
      pos_type   start_row;
      pos_type   start_column;
      pos_type   token_length;
      value_type number_value;
      logic      last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } lex_push_type;

   typedef enum logic [6:0] {
      ST_BEGIN      = 7'b0000001,
      ST_PRECOMMENT = 7'b0000010,
      ST_COMMENT    = 7'b0000100,
      ST_INT        = 7'b0001000,
      ST_FLOAT      = 7'b0010000,
      ST_STRING     = 7'b0100000,
      ST_IDENT      = 7'b1000000
   } lex_state_type;

   function automatic pos_type sat_inc(input pos_type v);
      return (v != POS_MAX) ? v + POS_ONE : POS_MAX;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   // chars are never zero, so a full compare also checks the length
   function automatic kind_type word_kind(input kw_word_type w, input logic too_long);
      kind_type k;
      k = K_IDENT;
      if (!too_long) begin
         for (int i = KW_COUNT - 1; i >= 0; i--) begin
            if (w == KW_TEXT[i]) begin
               k = K_KW0 + kind_type'(i);
            end
         end
      end
      return k;
   endfunction

endpackage

/* design/source_text_tokenizer_top.sv */
// Tokens of a request are written into the response queue when it is accepted and reach rsp from there.
// Throughput: one request per cycle; a four-entry response queue absorbs the
// second token a request can cause, and req_stall rises when fewer than two
// entries are free, so output bandwidth of one token per cycle sets the pace.
// Reset (synchronous): scanner returns to the begin state, row and column to 1,
// queue empties.
// Top level of the source text tokenizer. Depends on sttok_pkg, sttok_lexer,
// sttok_rsp_queue.
module source_text_tokenizer_top import sttok_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic         accept;
   logic         room_two;
   lex_push_type push;

   assign req_stall = ~room_two;
   assign accept    = req_valid & room_two;

   sttok_lexer u_lexer (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .push   (push)
   );

   sttok_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_valid & ~rsp_stall),
      .room_two  (room_two),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule

/* design/sttok_lexer.sv */
// Scanner state machine: takes one request per accepted cycle and produces
// up to two tokens for the response queue. Depends on sttok_pkg.
module sttok_lexer import sttok_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  req_type      req,
   output lex_push_type push
);

   lex_state_type state_ff, state_in;
   pos_type       row_ff, row_in;
   pos_type       col_ff, col_in;
   pos_type       tok_row_ff, tok_row_in;
   pos_type       tok_col_ff, tok_col_in;
   pos_type       tok_len_ff, tok_len_in;
   value_type     value_ff, value_in;
   kw_word_type   word_ff, word_in;
   logic          too_long_ff, too_long_in;
   logic          dot_ff, dot_in;

   logic          emit_a, emit_b, again;
   kind_type      kind_a, kind_b;
   logic [7:0]    c;
   logic [VALUE_WIDTH+3:0] value_wide;
   rsp_type       res_a, res_b;

   assign c = req.ch;
   assign value_wide = ({4'b0, value_ff} << 3) + ({4'b0, value_ff} << 1)
                     + {{VALUE_WIDTH{1'b0}}, c[3:0]};

   always_comb begin
      state_in    = state_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      tok_row_in  = tok_row_ff;
      tok_col_in  = tok_col_ff;
      tok_len_in  = tok_len_ff;
      value_in    = value_ff;
      word_in     = word_ff;
      too_long_in = too_long_ff;
      dot_in      = dot_ff;
      emit_a      = 1'b0;
      emit_b      = 1'b0;
      kind_a      = K_IDENT;
      kind_b      = K_IDENT;
      again       = 1'b0;

      if (req.end_of_text) begin
         unique case (state_ff)
            ST_PRECOMMENT: begin emit_a = 1'b1; kind_a = K_SUB;    end
            ST_INT:        begin emit_a = 1'b1; kind_a = K_INT;    end
            ST_FLOAT:      begin emit_a = 1'b1; kind_a = K_FLOAT;  end
            ST_STRING:     begin emit_a = 1'b1; kind_a = K_BADSTR; end
            ST_IDENT: begin
               emit_a = 1'b1;
               kind_a = word_kind(word_ff, too_long_ff);
            end
            default: ;
         endcase
         // start a new text
         state_in    = ST_BEGIN;
         row_in      = POS_ONE;
         col_in      = POS_ONE;
         tok_row_in  = '0;
         tok_col_in  = '0;
         tok_len_in  = '0;
         value_in    = '0;
         word_in     = '0;
         too_long_in = 1'b0;
         dot_in      = 1'b0;
      end else begin
         if ((state_ff == ST_INT) && dot_ff) begin
            dot_in = 1'b0;
            if (is_digit(c)) begin
               state_in   = ST_FLOAT;
               tok_len_in = sat_inc(sat_inc(tok_len_ff));
            end else begin
               emit_a = 1'b1;
               kind_a = K_INT;
               again  = 1'b1;
            end
         end else begin
            unique case (state_ff)
               ST_BEGIN: again = 1'b1;
               ST_PRECOMMENT: begin
                  if (c == CH_DASH) begin
                     state_in = ST_COMMENT;
                  end else begin
                     emit_a = 1'b1;
                     kind_a = K_SUB;
                     again  = 1'b1;
                  end
               end
               ST_COMMENT: begin
                  if (c == CH_NEWLINE) begin
                     state_in = ST_BEGIN;
                  end
               end
               ST_INT: begin
                  if (is_digit(c)) begin
                     value_in   = (value_wide > {4'b0, INT_SAT}) ? INT_SAT
                                                                  : value_wide[VALUE_WIDTH-1:0];
                     tok_len_in = sat_inc(tok_len_ff);
                  end else if (c == CH_DOT) begin
                     dot_in = 1'b1;
                  end else begin
                     emit_a = 1'b1;
                     kind_a = K_INT;
                     again  = 1'b1;
                  end
               end
               ST_FLOAT: begin
                  if (is_digit(c)) begin
                     tok_len_in = sat_inc(tok_len_ff);
                  end else begin
                     emit_a = 1'b1;
                     kind_a = K_FLOAT;
                     again  = 1'b1;
                  end
               end
               ST_STRING: begin
                  if (c == CH_QUOTE) begin
                     emit_a   = 1'b1;
                     kind_a   = K_STRING;
                     state_in = ST_BEGIN;
                  end else begin
                     tok_len_in = sat_inc(tok_len_ff);
                  end
               end
               ST_IDENT: begin
                  if (is_digit(c) || is_alpha(c) || (c == CH_UNDER) || (c == CH_DOT)
                      || (c == CH_DASH)) begin
                     if (tok_len_ff < pos_type'(MAX_KEYWORD_LEN)) begin
                        word_in = {word_ff[KW_BITS-9:0], c};
                     end else begin
                        too_long_in = 1'b1;
                     end
                     tok_len_in = sat_inc(tok_len_ff);
                  end else begin
                     emit_a = 1'b1;
                     kind_a = word_kind(word_ff, too_long_ff);
                     again  = 1'b1;
                  end
               end
               default: again = 1'b1;
            endcase
         end

         // rescan the byte from the begin state
         if (again) begin
            state_in = ST_BEGIN;
            priority if (c == CH_PLUS) begin
               emit_b = 1'b1; kind_b = K_ADD;
            end else if (c == CH_STAR) begin
               emit_b = 1'b1; kind_b = K_MUL;
            end else if (c == CH_SLASH) begin
               emit_b = 1'b1; kind_b = K_DIV;
            end else if (c == CH_COMMA) begin
               emit_b = 1'b1; kind_b = K_COMMA;
            end else if (c == CH_LPAREN) begin
               emit_b = 1'b1; kind_b = K_LPAREN;
            end else if (c == CH_RPAREN) begin
               emit_b = 1'b1; kind_b = K_RPAREN;
            end else if (c == CH_DASH) begin
               state_in   = ST_PRECOMMENT;
               tok_row_in = row_ff;
               tok_col_in = col_ff;
               tok_len_in = POS_ONE;
            end else if (c == CH_QUOTE) begin
               state_in   = ST_STRING;
               tok_row_in = row_ff;
               tok_col_in = col_ff;
               tok_len_in = '0;
            end else if (is_alpha(c) || (c == CH_UNDER)) begin
               state_in    = ST_IDENT;
               tok_row_in  = row_ff;
               tok_col_in  = col_ff;
               tok_len_in  = POS_ONE;
               word_in     = {{(KW_BITS-8){1'b0}}, c};
               too_long_in = 1'b0;
            end else if (is_digit(c)) begin
               state_in   = ST_INT;
               tok_row_in = row_ff;
               tok_col_in = col_ff;
               tok_len_in = POS_ONE;
               value_in   = {{(VALUE_WIDTH-4){1'b0}}, c[3:0]};
               dot_in     = 1'b0;
            end else begin
               // drop unknown byte
            end
         end

         if (c == CH_NEWLINE) begin
            row_in = sat_inc(row_ff);
            col_in = POS_ONE;
         end else begin
            col_in = sat_inc(col_ff);
         end
      end
   end

   always_comb begin
      res_a.token_kind   = kind_a;
      res_a.start_row    = tok_row_ff;
      res_a.start_column = tok_col_ff;
      res_a.token_length = tok_len_ff;
      res_a.number_value = (kind_a == K_INT) ? value_ff : '0;
      res_a.last         = ~emit_b;

      res_b.token_kind   = kind_b;
      res_b.start_row    = row_ff;
      res_b.start_column = col_ff;
      res_b.token_length = POS_ONE;
      res_b.number_value = '0;
      res_b.last         = 1'b1;

      if (emit_a) begin
         push.count  = emit_b ? 2'd2 : 2'd1;
         push.first  = res_a;
         push.second = res_b;
      end else begin
         push.count  = emit_b ? 2'd1 : 2'd0;
         push.first  = res_b;
         push.second = res_b;
      end
      if (!accept) begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_BEGIN;
         row_ff      <= POS_ONE;
         col_ff      <= POS_ONE;
         tok_row_ff  <= '0;
         tok_col_ff  <= '0;
         tok_len_ff  <= '0;
         value_ff    <= '0;
         word_ff     <= '0;
         too_long_ff <= 1'b0;
         dot_ff      <= 1'b0;
      end else if (accept) begin
         state_ff    <= state_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         tok_row_ff  <= tok_row_in;
         tok_col_ff  <= tok_col_in;
         tok_len_ff  <= tok_len_in;
         value_ff    <= value_in;
         word_ff     <= word_in;
         too_long_ff <= too_long_in;
         dot_ff      <= dot_in;
      end
   end

endmodule

/* design/sttok_rsp_queue.sv */
// Response queue: takes up to two tokens per cycle, hands out one per cycle on pop.
// Depends on sttok_pkg.
module sttok_rsp_queue import sttok_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  lex_push_type push,
   input  logic         pop,
   output logic         room_two,
   output logic         out_valid,
   output rsp_type      out_data
);

   rsp_type                entry_ff [RSPQ_DEPTH];
   logic [RSPQ_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [RSPQ_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [RSPQ_CNT_W-1:0]  count_ff, count_in;
   logic [RSPQ_PTR_W-1:0]  wr_next;

   assign wr_next   = wr_ptr_ff + RSPQ_PTR_W'(1);
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign room_two  = (count_ff <= RSPQ_CNT_W'(RSPQ_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSPQ_PTR_W'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + RSPQ_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + RSPQ_CNT_W'(push.count) - RSPQ_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
